// ----- hdl/a2lp_pkg.sv -----
// Shared types and constants for the start code to length prefix unit.
package a2lp_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned CountW = 16;

  // Byte positions wrap at this frame size, then are kept to PosW bits.
  localparam logic [32:0] MaxFrameBytes = 33'd16777216;

  localparam logic [7:0]        CodeLastByte = 8'h01;
  localparam logic [CountW-1:0] CountMax     = '1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic              patch_valid;
    logic [PosW-1:0]   write_offset;
    logic [PosW-1:0]   slice_length;
    logic              done_res;
    logic [CountW-1:0] slices_found;
  } out_item_t;

endpackage

// ----- hdl/a2lp_scan.sv -----
// Start code scanner: frame state, code detection and patch generation.
module a2lp_scan
  import a2lp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  input  logic      step_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  logic [23:0]       recent_q, recent_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   prev_q, prev_d;
  logic [CountW-1:0] count_q, count_d;

  logic              code_hit;
  logic [PosW-1:0]   code_off;
  logic [PosW:0]     pos_inc;
  logic [PosW-1:0]   frame_len;

  assign code_hit = !item_i.frame_end && (pos_q >= PosW'(3)) && (recent_q == '0)
                    && (item_i.data_byte == CodeLastByte);
  assign code_off  = pos_q - PosW'(3);
  assign pos_inc   = {1'b0, pos_q} + (PosW+1)'(1);
  assign frame_len = pos_q + PosW'(1);

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    recent_d    = {recent_q[15:0], item_i.data_byte};
    prev_d      = prev_q;
    count_d     = count_q;
    if ({{(32-PosW){1'b0}}, pos_inc} == MaxFrameBytes) begin
      pos_d = '0;
    end else begin
      pos_d = pos_inc[PosW-1:0];
    end

    if (item_i.frame_end) begin
      // The closing transfer always goes out and the frame state starts over.
      res_valid_o = 1'b1;
      res_o.done_res = 1'b1;
      if (count_q != '0) begin
        res_o.patch_valid  = 1'b1;
        res_o.write_offset = prev_q;
        res_o.slice_length = frame_len - prev_q - PosW'(4);
        res_o.slices_found = count_q;
      end
      recent_d = '0;
      pos_d    = '0;
      prev_d   = '0;
      count_d  = '0;
    end else if (code_hit) begin
      if (count_q != '0) begin
        res_valid_o        = 1'b1;
        res_o.patch_valid  = 1'b1;
        res_o.write_offset = prev_q;
        res_o.slice_length = code_off - prev_q - PosW'(4);
      end
      prev_d = code_off;
      if (count_q != CountMax) begin
        count_d = count_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '0;
      pos_q    <= '0;
      prev_q   <= '0;
      count_q  <= '0;
    end else if (step_i) begin
      recent_q <= recent_d;
      pos_q    <= pos_d;
      prev_q   <= prev_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.frame_end |=> pos_q == '0 && count_q == '0 && recent_q == '0)
    else $error("frame state not cleared after the last byte");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CountMax && !(step_i && item_i.frame_end) |=> count_q == CountMax)
    else $error("saturated code count changed within the frame");

  a_code_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && code_hit |=> count_q != '0 && prev_q == $past(code_off))
    else $error("start code not recorded");
`endif

endmodule

// ----- hdl/annexb_start_code_to_length_prefix_unit.sv -----
// Annex B start code to length prefix unit: input register, scanner, result register.
//
// Usage: feed the bytes of one frame in order on the input channel, one per
// transfer, with frame_end set on the last byte. Every 00 00 00 01 start code
// found (except one whose 01 byte is the last byte) yields a patch for the
// previous code, if any: its offset and the slice length to write big-endian over it.
// The last byte always yields a closing transfer with done_res set, carrying
// the final patch (if any code was seen) and the saturating code count.
// Channels use valid/stall; a transfer happens when valid is high and stall
// is low. An accepted byte is held in the input register and its result in the
// result register. Throughput is one byte per cycle while no result waits on a
// stalled output; a byte that gives no result never waits on the output side.
// When the receiver stalls, the result register holds its transfer and the
// input register keeps taking bytes until a second result needs the output,
// then input stall is raised. Reset clears the frame state and the valid bits of both
// register stages; the first byte after reset starts a new frame at offset zero.
module annexb_start_code_to_length_prefix_unit
  import a2lp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  logic      res_valid;
  out_item_t res;
  logic      out_free;
  logic      advance;
  logic      in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!res_valid || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  a2lp_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (in_q),
    .step_i     (advance),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = advance && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take || advance) begin
        in_valid_q <= in_take;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_i;
    end
    if (out_free && advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_no_patch_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.patch_valid |->
      out_o.done_res && out_o.write_offset == '0 && out_o.slice_length == '0
      && out_o.slices_found == '0)
    else $error("closing transfer without patch carries nonzero fields");

  a_mid_patch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.done_res |-> out_o.patch_valid && out_o.slices_found == '0)
    else $error("mid-frame transfer is malformed");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && in_valid_q && res_valid |-> in_stall_o)
    else $error("result would overwrite a stalled output transfer");
`endif

endmodule
